>>> sv/awbs_pkg.sv
// shared types, codes and constants of the affine warp bilinear sampler
`default_nettype none
package awbs_pkg;

    localparam int REF_PITCH_DEFAULT = 256;
    localparam int ADDR_W = 16;
    localparam int PIX_W = 8;
    localparam int ROW_PIXELS = 8;
    localparam int COL_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // input item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ORIGIN = 2'd1;
    localparam logic [1:0] MODE_ROW = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X_COL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y_ROW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIC_WIDTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PIC_HEIGHT = 3'd7;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        ref_address;
        logic [7:0]         ref_pixel;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic [2:0] out_column;
        logic       row_last;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic addr_calc;
        logic rd_top;
        logic rd_bot;
        logic horz;
        logic vert;
        logic emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic col_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

>>> sv/awbs_ctrl.sv
// sequencer for load, origin and row items of the sampler
`default_nettype none
module awbs_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic [1:0]      s_mode,
    output logic                 s_ready,
    input  wire awbs_pkg::stat_t stat,
    output awbs_pkg::cmd_t       cmd
);
    import awbs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ADDR   = 7'b0000010,
        S_RD_TOP = 7'b0000100,
        S_RD_BOT = 7'b0001000,
        S_HORZ   = 7'b0010000,
        S_VERT   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid && s_mode == MODE_ROW) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                cmd.addr_calc = 1'b1;
                state_next = S_RD_TOP;
            end
            S_RD_TOP: begin
                cmd.rd_top = 1'b1;
                state_next = S_RD_BOT;
            end
            S_RD_BOT: begin
                cmd.rd_bot = 1'b1;
                state_next = S_HORZ;
            end
            S_HORZ: begin
                cmd.horz = 1'b1;
                state_next = S_VERT;
            end
            S_VERT: begin
                cmd.vert = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = stat.col_last ? S_IDLE : S_ADDR;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/awbs_datapath.sv
// reference store, coordinate stepping and bilinear blend of the sampler
`default_nettype none
module awbs_datapath #(
    parameter int REF_PITCH = awbs_pkg::REF_PITCH_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire awbs_pkg::in_item_t               s_data,
    input  wire awbs_pkg::cmd_t                   cmd,
    output awbs_pkg::stat_t                       stat,
    input  wire logic                             cfg_wr_en,
    input  wire logic [awbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [awbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output awbs_pkg::out_item_t                   m_data
);
    import awbs_pkg::*;

    localparam logic [ADDR_W-1:0] PITCH_W = ADDR_W'(REF_PITCH);

    // configuration
    logic [31:0] step_x_col_reg, step_x_row_reg, step_y_col_reg, step_y_row_reg;
    logic [2:0]  frac_bits_reg;
    logic [7:0]  round_reg;
    logic [8:0]  pic_width_reg, pic_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_col_reg <= 32'd65536;
            step_x_row_reg <= 32'd0;
            step_y_col_reg <= 32'd0;
            step_y_row_reg <= 32'd65536;
            frac_bits_reg <= 3'd1;
            round_reg <= 8'd0;
            pic_width_reg <= 9'd256;
            pic_height_reg <= 9'd256;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_X_COL: step_x_col_reg <= cfg_data;
                REG_STEP_X_ROW: step_x_row_reg <= cfg_data;
                REG_STEP_Y_COL: step_y_col_reg <= cfg_data;
                REG_STEP_Y_ROW: step_y_row_reg <= cfg_data;
                REG_FRAC_BITS: frac_bits_reg <= cfg_data[2:0];
                REG_ROUND: round_reg <= cfg_data[7:0];
                REG_PIC_WIDTH: pic_width_reg <= cfg_data[8:0];
                REG_PIC_HEIGHT: pic_height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // row origin, pixel coordinates and column count
    logic [31:0] ox_reg, oy_reg, vx_reg, vy_reg;
    logic [COL_W-1:0] col_reg;
    logic row_start;

    assign row_start = cmd.accept && s_data.mode == MODE_ROW;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg <= '0;
            oy_reg <= '0;
            col_reg <= '0;
        end else begin
            if (cmd.accept && s_data.mode == MODE_ORIGIN) begin
                ox_reg <= s_data.origin_x;
                oy_reg <= s_data.origin_y;
            end
            if (row_start) begin
                col_reg <= '0;
            end else if (cmd.emit) begin
                col_reg <= col_reg + COL_W'(1);
                if (col_reg == COL_W'(ROW_PIXELS - 1)) begin
                    ox_reg <= ox_reg + step_x_row_reg;
                    oy_reg <= oy_reg + step_y_row_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (row_start) begin
            vx_reg <= ox_reg;
            vy_reg <= oy_reg;
        end else if (cmd.emit) begin
            vx_reg <= vx_reg + step_x_col_reg;
            vy_reg <= vy_reg + step_y_col_reg;
        end
    end

    // integer and fraction parts, edge tests, clamped base address
    logic [7:0]  s_val, frac_mask;
    logic signed [15:0] ix, iy;
    logic [7:0]  fx, fy;
    logic [8:0]  wlim, hlim;
    logic        x_in, y_in;
    logic [15:0] cx, cy;
    logic [ADDR_W-1:0] base;

    always_comb begin
        s_val = 8'd1 << frac_bits_reg;
        frac_mask = s_val - 8'd1;
        fx = vx_reg[23:16] & frac_mask;
        fy = vy_reg[23:16] & frac_mask;
        ix = $signed(vx_reg[31:16]) >>> frac_bits_reg;
        iy = $signed(vy_reg[31:16]) >>> frac_bits_reg;
        wlim = ((pic_width_reg == 9'd0) ? 9'd1 : pic_width_reg) - 9'd1;
        hlim = ((pic_height_reg == 9'd0) ? 9'd1 : pic_height_reg) - 9'd1;
        x_in = !ix[15] && (ix < $signed({7'd0, wlim}));
        y_in = !iy[15] && (iy < $signed({7'd0, hlim}));
        cx = ix[15] ? 16'd0 : (x_in ? ix : {7'd0, wlim});
        cy = iy[15] ? 16'd0 : (y_in ? iy : {7'd0, hlim});
        base = ADDR_W'(32'(cx) + 32'(cy) * 32'(REF_PITCH));
    end

    logic [ADDR_W-1:0] base_reg;
    logic [7:0] wx1_reg, wy1_reg, wx0_reg, wy0_reg;
    logic xin_reg, yin_reg;

    always_ff @(posedge aclk) begin
        if (cmd.addr_calc) begin
            base_reg <= base;
            xin_reg <= x_in;
            yin_reg <= y_in;
            wx1_reg <= x_in ? fx : 8'd0;
            wy1_reg <= y_in ? fy : 8'd0;
            wx0_reg <= s_val - (x_in ? fx : 8'd0);
            wy0_reg <= s_val - (y_in ? fy : 8'd0);
        end
    end

    // reference store, one write and two registered reads
    logic [PIX_W-1:0] ref_mem [0:(1 << ADDR_W)-1];
    logic [ADDR_W-1:0] ra0, ra1;
    logic [PIX_W-1:0] rdata0_reg, rdata1_reg;

    assign ra0 = cmd.rd_bot ? base_reg + PITCH_W : base_reg;
    assign ra1 = ra0 + ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_data.mode == MODE_LOAD) begin
            ref_mem[s_data.ref_address] <= s_data.ref_pixel;
        end
        if (cmd.rd_top || cmd.rd_bot) begin
            rdata0_reg <= ref_mem[ra0];
            rdata1_reg <= ref_mem[ra1];
        end
    end

    // upper pair capture, then horizontal blend of both rows
    logic [7:0]  a_reg, b_reg;
    logic [15:0] htop_reg, hbot_reg;
    logic [7:0]  b_sel, c_sel, d_sel;

    assign b_sel = xin_reg ? b_reg : 8'd0;
    assign c_sel = yin_reg ? rdata0_reg : 8'd0;
    assign d_sel = (xin_reg && yin_reg) ? rdata1_reg : 8'd0;

    always_ff @(posedge aclk) begin
        if (cmd.rd_bot) begin
            a_reg <= rdata0_reg;
            b_reg <= rdata1_reg;
        end
        if (cmd.horz) begin
            htop_reg <= 16'(a_reg * wx0_reg) + 16'(b_sel * wx1_reg);
            hbot_reg <= 16'(c_sel * wx0_reg) + 16'(d_sel * wx1_reg);
        end
    end

    // vertical blend
    logic [22:0] v_reg;

    always_ff @(posedge aclk) begin
        if (cmd.vert) begin
            v_reg <= 23'(htop_reg * wy0_reg) + 23'(hbot_reg * wy1_reg);
        end
    end

    // round, shift and output register
    logic [22:0] v_round;
    logic [7:0]  pix;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    always_comb begin
        v_round = (v_reg + 23'(round_reg)) >> {frac_bits_reg, 1'b0};
        pix = (!xin_reg && !yin_reg) ? a_reg : v_round[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.out_pixel <= pix;
            m_data_reg.out_column <= col_reg;
            m_data_reg.row_last <= (col_reg == COL_W'(ROW_PIXELS - 1));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
    assign stat.col_last = (col_reg == COL_W'(ROW_PIXELS - 1));
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

>>> sv/affine_warp_bilinear_sampler_top.sv
// top level of the affine warp bilinear sampler
//
// input channel s_valid/s_ready/s_data carries three kinds of item:
//   load: writes one 8-bit pixel into the 64K-entry reference store
//   origin: sets the row origin
//   row: produces 8 pixels on m_valid/m_ready/m_data, columns 0 to 7,
//   with row_last on column 7; the origin then moves by the row steps
// a row works through its pixels one at a time: each
// pixel walks address, upper read, lower read, horizontal blend, vertical
// blend and output; the two-port store read of the two pixel pairs sets
// the per-pixel cost. the first pixel is registered in the output step.
// s_ready is high only between items, one item at a time.
// configuration goes through cfg_wr_en/cfg_index/cfg_data, one register per
// write; the user must do it only while the block is idle (not enforced).
// reset (aresetn low, synchronous) restores the register defaults and a
// zero origin; the store is not cleared and holds no data until loaded.
// a stalled receiver holds the output register; the pixel sequence waits
// in the output step until the transfer goes through.
`default_nettype none
module affine_warp_bilinear_sampler_top #(
    parameter int REF_PITCH = awbs_pkg::REF_PITCH_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire awbs_pkg::in_item_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output awbs_pkg::out_item_t                   m_data,
    input  wire logic                             cfg_wr_en,
    input  wire logic [awbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [awbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import awbs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    awbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // store and arithmetic
    awbs_datapath #(
        .REF_PITCH (REF_PITCH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // row_last marks the final column only
    a_row_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.row_last == (m_data.out_column == 3'd7)))
        else $error("row_last does not match column");

    // a row transfer blocks further input
    a_row_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_ROW) |=> !s_ready)
        else $error("input taken during row");

    // a fresh output never shows right after any input item is accepted
    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !($rose(m_valid)))
        else $error("output appeared right after input transfer");

endmodule
`default_nettype wire

>>> verif/awbs_checker.sv
// checker for the affine warp bilinear sampler: predicts row pixels and compares them
`timescale 1ns / 100ps
`default_nettype none
module awbs_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire awbs_pkg::in_item_t              s_data,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire awbs_pkg::out_item_t             m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [awbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [awbs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   fail_count,
    output int                                   pending_count
);
    import awbs_pkg::*;

    logic [7:0]  ref_mem [0:65535];
    logic [31:0] org_x, org_y;
    logic [31:0] sx_col, sx_row, sy_col, sy_row;
    logic [2:0]  frac;
    logic [7:0]  rnd;
    logic [8:0]  pw, ph;
    out_item_t   pixel_fifo [$];

    function automatic logic [31:0] rd(input logic [31:0] a);
        return {24'd0, ref_mem[a[15:0]]};
    endfunction

    function automatic logic [31:0] clamp_hi(input logic [31:0] v, input logic [31:0] hi);
        if (v[31]) return 0;
        return (v > hi) ? hi : v;
    endfunction

    // bilinear sample at one fixed point position
    function automatic logic [7:0] warp_sample(input logic [31:0] vx, input logic [31:0] vy);
        logic [31:0] s, wl, hl, ix, iy, fx, fy, idx, v;
        s  = 32'd1 << frac;
        wl = ((pw == 0) ? 32'd1 : {23'd0, pw}) - 1;
        hl = ((ph == 0) ? 32'd1 : {23'd0, ph}) - 1;
        ix = $signed(vx) >>> 16;
        iy = $signed(vy) >>> 16;
        fx = ix & (s - 1);
        fy = iy & (s - 1);
        ix = $signed(ix) >>> frac;
        iy = $signed(iy) >>> frac;
        if (ix < wl) begin
            if (iy < hl) begin
                idx = ix + iy * REF_PITCH_DEFAULT;
                v = (rd(idx) * (s - fx) + rd(idx + 1) * fx) * (s - fy)
                  + (rd(idx + REF_PITCH_DEFAULT) * (s - fx)
                     + rd(idx + REF_PITCH_DEFAULT + 1) * fx) * fy;
            end else begin
                idx = ix + clamp_hi(iy, hl) * REF_PITCH_DEFAULT;
                v = (rd(idx) * (s - fx) + rd(idx + 1) * fx) * s;
            end
        end else begin
            if (iy < hl) begin
                idx = clamp_hi(ix, wl) + iy * REF_PITCH_DEFAULT;
                v = (rd(idx) * (s - fy) + rd(idx + REF_PITCH_DEFAULT) * fy) * s;
            end else begin
                idx = clamp_hi(ix, wl) + clamp_hi(iy, hl) * REF_PITCH_DEFAULT;
                return ref_mem[idx[15:0]];
            end
        end
        v = (v + rnd) >> (2 * frac);
        return v[7:0];
    endfunction

    // register writes, predictions and comparisons
    always @(posedge aclk) begin
        logic [31:0] vx, vy;
        out_item_t   want;
        if (!aresetn) begin
            org_x <= 0; org_y <= 0;
            sx_col <= 32'd65536; sx_row <= 0; sy_col <= 0; sy_row <= 32'd65536;
            frac <= 3'd1; rnd <= 0; pw <= 9'd256; ph <= 9'd256;
            fail_count <= 0;
            pixel_fifo.delete();
            pending_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_X_COL: sx_col <= cfg_data;
                    REG_STEP_X_ROW: sx_row <= cfg_data;
                    REG_STEP_Y_COL: sy_col <= cfg_data;
                    REG_STEP_Y_ROW: sy_row <= cfg_data;
                    REG_FRAC_BITS: frac <= cfg_data[2:0];
                    REG_ROUND: rnd <= cfg_data[7:0];
                    REG_PIC_WIDTH: pw <= cfg_data[8:0];
                    REG_PIC_HEIGHT: ph <= cfg_data[8:0];
                    default: ;
                endcase
            end
            // output transfer check
            if (m_valid && m_ready) begin
                if (pixel_fifo.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected pixel transfer %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_fifo.pop_front();
                    if (m_data !== want) begin
                        if (fail_count < 10)
                            $display("pixel mismatch: expected %p, got %p", want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // input transfer prediction
            if (s_valid && s_ready) begin
                case (s_data.mode)
                    MODE_LOAD: ref_mem[s_data.ref_address] = s_data.ref_pixel;
                    MODE_ORIGIN: begin
                        org_x <= s_data.origin_x;
                        org_y <= s_data.origin_y;
                    end
                    MODE_ROW: begin
                        vx = org_x;
                        vy = org_y;
                        for (int k = 0; k < ROW_PIXELS; k++) begin
                            want.out_pixel = warp_sample(vx, vy);
                            want.out_column = k[2:0];
                            want.row_last = (k == ROW_PIXELS - 1);
                            pixel_fifo.push_back(want);
                            vx = vx + sx_col;
                            vy = vy + sy_col;
                        end
                        org_x <= org_x + sx_row;
                        org_y <= org_y + sy_row;
                    end
                    default: ;
                endcase
            end
            pending_count <= pixel_fifo.size();
        end
    end
endmodule
`default_nettype wire

>>> verif/tb.sv
// stimulus and verdict for the affine warp bilinear sampler
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import awbs_pkg::*;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    in_item_t  s_data;
    out_item_t m_data;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count, pending_count;
    int send_idle_pct, recv_stall_pct;
    bit long_hold;

    // the small picture used by most rows spans 6 columns by 6 rows

    affine_warp_bilinear_sampler_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    awbs_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // valid stays up after the transfer until the next idle or other step
    task automatic send(input in_item_t it);
        cfg_wr_en <= 0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_px(input logic [15:0] a, input logic [7:0] p);
        in_item_t it;
        it = '0;
        it.mode = MODE_LOAD; it.ref_address = a; it.ref_pixel = p;
        send(it);
    endtask

    task automatic set_origin(input logic [31:0] ox, input logic [31:0] oy);
        in_item_t it;
        it = '0;
        it.ref_address = 16'($urandom());
        it.ref_pixel = 8'($urandom());
        it.mode = MODE_ORIGIN; it.origin_x = ox; it.origin_y = oy;
        send(it);
    endtask

    task automatic emit_row();
        in_item_t it;
        it = '0;
        it.ref_address = 16'($urandom());
        it.ref_pixel = 8'($urandom());
        it.origin_x = $urandom();
        it.origin_y = $urandom();
        it.mode = MODE_ROW;
        send(it);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        s_valid <= 0;
        cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= d;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        cfg_wr_en <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // position of pixel p plus fraction fr in the 16.frac format
    function automatic logic [31:0] pos(input int p, input int f, input int fr);
        return ((p << f) + fr) << 16;
    endfunction

    // settings that keep every read inside the loaded 6x6 patch
    task automatic safe_cfg(input int f, input int w, input int h);
        cfg_write(REG_FRAC_BITS, f);
        cfg_write(REG_ROUND, $urandom_range(255));
        cfg_write(REG_PIC_WIDTH, w);
        cfg_write(REG_PIC_HEIGHT, h);
        cfg_write(REG_STEP_X_COL, $urandom_range(1 << f, 0) << 16);
        cfg_write(REG_STEP_Y_COL, $urandom_range(1 << f, 0) << 16);
        cfg_write(REG_STEP_X_ROW, $signed(32'($urandom_range(2 << f, 0))
            - (1 << f)) << 16);
        cfg_write(REG_STEP_Y_ROW, $urandom_range(1 << f, 0) << 16);
    endtask

    // origin anywhere, including far outside, that clamps into the patch
    task automatic random_origin(input int f);
        case ($urandom_range(3))
            0: set_origin($urandom(), $urandom());
            default: set_origin(pos($urandom_range(7), f, $urandom_range((1 << f) - 1)),
                                pos($urandom_range(7), f, $urandom_range((1 << f) - 1)));
        endcase
    endtask

    initial begin
        int f, w, h;
        s_valid = 0; s_data = '0; cfg_wr_en = 0; cfg_index = '0; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; long_hold = 0;
        aresetn = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // load the patch, extremes in the corners
        for (int r = 0; r < 6; r++)
            for (int c = 0; c < 6; c++)
                load_px(16'(r * 256 + c), (r + c == 0) ? 8'hff :
                        (r == 5 && c == 5) ? 8'h00 : 8'($urandom()));
        load_px(16'hffff, 8'h5a);
        load_px(16'h0100 * 8'hff, 8'ha5);

        // directed: reset settings, clamp regions, ignored mode, extremes
        set_origin(0, 0);
        emit_row();
        begin
            in_item_t it;
            it = '1;
            send(it);
        end
        drain();
        cfg_write(REG_PIC_WIDTH, 0);
        cfg_write(REG_PIC_HEIGHT, 0);
        cfg_write(REG_FRAC_BITS, 7);
        cfg_write(REG_ROUND, 255);
        set_origin(32'h7fffffff, 32'h80000000);
        emit_row();
        drain();
        safe_cfg(0, 3, 6);
        set_origin(pos(1, 0, 0), pos(5, 0, 0));
        emit_row();
        emit_row();
        drain();
        safe_cfg(4, 6, 3);
        set_origin(pos(5, 4, 15), pos(1, 4, 15));
        emit_row();
        emit_row();
        drain();
        safe_cfg(2, 1, 1);
        set_origin(pos(3, 2, 1), pos(3, 2, 3));
        emit_row();
        drain();

        // random phases with varying settings and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 64; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 64; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            f = $urandom_range(4);
            w = (ph == 3) ? 6 : $urandom_range(6, 1);
            h = (ph == 5) ? 6 : $urandom_range(6, 1);
            safe_cfg(f, w, h);
            if (ph == 2) long_hold = 1;
            for (int n = 0; n < 6; n++) begin
                case ($urandom_range(5))
                    0: load_px(16'($urandom_range(5) * 256 + $urandom_range(5)), $urandom());
                    1: random_origin(f);
                    default: begin
                        // keep the row reads inside the patch
                        random_origin(f);
                        emit_row();
                    end
                endcase
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
